### sv/tjik_pkg.sv
// ----------------------------------------------------------------------------
// tjik_pkg
// Shared constants, codes and types of the three-joint leg inverse
// kinematics core.
// ----------------------------------------------------------------------------
package tjik_pkg;

	localparam int CORDIC_STEPS_DEF        = 16;
	localparam int COORD_BITS_DEF          = 16;
	localparam int ANGLE_FRACTION_BITS_DEF = 6;

	localparam int AQ      = 20;
	localparam int ANG_W   = 32;
	localparam int CW      = 42;
	localparam int NW      = 38;
	localparam int AW      = 35;
	localparam int LEN_W   = 12;
	localparam int DQ_W    = 18;
	localparam int NORM_SH = 30;

	localparam logic [23:0]              INVK_Q24      = 24'd10188014;
	localparam logic [29:0]              INV_SQRT2_Q30 = 30'd759250125;
	localparam logic signed [ANG_W-1:0]  DEG90         = 32'sd94371840;
	localparam logic [DQ_W-1:0]          DIAG_MAX      = 18'd131072;

	localparam logic signed [31:0] ATAN_Q20 [32] = '{
		32'sd47185920, 32'sd27855475, 32'sd14718068, 32'sd7471121,
		32'sd3750058,  32'sd1876857,  32'sd938658,   32'sd469357,
		32'sd234682,   32'sd117342,   32'sd58671,    32'sd29335,
		32'sd14668,    32'sd7334,     32'sd3667,     32'sd1833,
		32'sd917,      32'sd458,      32'sd229,      32'sd115,
		32'sd57,       32'sd29,       32'sd14,       32'sd7,
		32'sd4,        32'sd2,        32'sd1,        32'sd0,
		32'sd0,        32'sd0,        32'sd0,        32'sd0
	};

	typedef enum logic [7:0] {
		REG_COXA   = 8'd0,
		REG_FEMUR  = 8'd1,
		REG_TIBIA  = 8'd2,
		REG_CORNER = 8'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		CORNER_BACK_LEFT   = 2'd0,
		CORNER_FRONT_RIGHT = 2'd1,
		CORNER_FRONT_LEFT  = 2'd2,
		CORNER_BACK_RIGHT  = 2'd3
	} corner_t;

	typedef struct packed {
		logic        fault;
		logic [13:0] bend;
		logic [15:0] pitch;
		logic [14:0] yaw;
	} out_beat_t;

endpackage

### sv/tjik_vec_cordic.sv
// ----------------------------------------------------------------------------
// tjik_vec_cordic
// Pipelined vectoring CORDIC: quadrant pre-rotation stage, then one stage per
// micro-rotation. Returns atan2(y, x) in 1/2^20 degree and the unscaled x.
// ----------------------------------------------------------------------------
module tjik_vec_cordic
	import tjik_pkg::*;
#(
	parameter int W     = CW,
	parameter int STEPS = CORDIC_STEPS_DEF,
	parameter int SW    = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic                    in_clr,
	input  logic signed [W-1:0]     in_x,
	input  logic signed [W-1:0]     in_y,
	input  logic [SW-1:0]           in_side,
	output logic                    out_valid,
	output logic signed [ANG_W-1:0] out_angle,
	output logic signed [W-1:0]     out_x,
	output logic [SW-1:0]           out_side
);

	logic signed [W-1:0]     cx_s [0:STEPS];
	logic signed [W-1:0]     cy_s [0:STEPS];
	logic signed [ANG_W-1:0] cz_s [0:STEPS];
	logic [SW:0]             cc_s [0:STEPS];
	logic [STEPS:0]          cv_s;

	logic signed [W-1:0]     px, py;
	logic signed [ANG_W-1:0] pz;
	logic                    pclr;

	always_comb begin
		px   = in_x;
		py   = in_y;
		pz   = '0;
		pclr = in_clr || (in_x == '0 && in_y == '0);
		if (in_x < 0) begin
			if (in_y >= 0) begin
				px = in_y;
				py = -in_x;
				pz = DEG90;
			end else begin
				px = -in_y;
				py = in_x;
				pz = -DEG90;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s <= '0;
		end else if (en) begin
			cv_s <= {cv_s[STEPS-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= px;
			cy_s[0] <= py;
			cz_s[0] <= pz;
			cc_s[0] <= {pclr, in_side};
			for (int g = 0; g < STEPS; g++) begin
				cc_s[g+1] <= cc_s[g];
				if (cy_s[g] >= 0) begin
					cx_s[g+1] <= cx_s[g] + (cy_s[g] >>> g);
					cy_s[g+1] <= cy_s[g] - (cx_s[g] >>> g);
					cz_s[g+1] <= cz_s[g] + ATAN_Q20[g];
				end else begin
					cx_s[g+1] <= cx_s[g] - (cy_s[g] >>> g);
					cy_s[g+1] <= cy_s[g] + (cx_s[g] >>> g);
					cz_s[g+1] <= cz_s[g] - ATAN_Q20[g];
				end
			end
		end
	end

	assign out_valid = cv_s[STEPS];
	assign out_angle = cc_s[STEPS][SW] ? '0 : cz_s[STEPS];
	assign out_x     = cx_s[STEPS];
	assign out_side  = cc_s[STEPS][SW-1:0];

endmodule

### sv/tjik_mag.sv
// ----------------------------------------------------------------------------
// tjik_mag
// CORDIC gain removal: x times 1/K in Q24, split into two partial products
// over two stages.
// ----------------------------------------------------------------------------
module tjik_mag
	import tjik_pkg::*;
#(
	parameter int W  = CW,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [W-1:0]  in_x,
	input  logic [SW-1:0] in_side,
	output logic          out_valid,
	output logic [W-1:0]  out_mag,
	output logic [SW-1:0] out_side
);

	localparam int LO_W = W / 2;
	localparam int HI_W = W - LO_W;

	logic [HI_W+23:0] phi_s1;
	logic [LO_W+23:0] plo_s1;
	logic [SW-1:0]    side_s1;
	logic [W-1:0]     mag_s2;
	logic [SW-1:0]    side_s2;
	logic [1:0]       v_q;
	logic [W+23:0]    sum;

	assign sum = {phi_s1, {LO_W{1'b0}}} + (W+24)'(plo_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phi_s1  <= in_x[W-1:LO_W] * INVK_Q24;
			plo_s1  <= in_x[LO_W-1:0] * INVK_Q24;
			side_s1 <= in_side;
			mag_s2  <= sum[W+23:24];
			side_s2 <= side_s1;
		end
	end

	assign out_valid = v_q[1];
	assign out_mag   = mag_s2;
	assign out_side  = side_s2;

endmodule

### sv/tjik_acos.sv
// ----------------------------------------------------------------------------
// tjik_acos
// Pipelined arc cosine of num/den: clamp and fault, normalize den into
// [2^30, 2^31), square, bit-pair square root, then atan2 by CORDIC.
// ----------------------------------------------------------------------------
module tjik_acos
	import tjik_pkg::*;
#(
	parameter int STEPS = CORDIC_STEPS_DEF,
	parameter int SW    = 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [NW-1:0]    in_num,
	input  logic signed [NW-1:0]    in_den,
	input  logic [SW-1:0]           in_side,
	output logic                    out_valid,
	output logic signed [ANG_W-1:0] out_angle,
	output logic                    out_fault,
	output logic [SW-1:0]           out_side
);

	localparam int MSB_W = $clog2(NW);
	localparam int NB    = 33;
	localparam int RW    = 62;
	localparam int ISQ   = 31;
	localparam int KW    = SW + 2 + NB;
	localparam int LAT   = 4 + ISQ;

	logic [LAT-1:0] v_q;

	// stage a
	logic signed [NW-1:0] numc;
	logic                 zero, flt;
	logic [MSB_W-1:0]     msb;
	logic signed [NW-1:0] num_s1, den_s1;
	logic [MSB_W-1:0]     msb_s1;
	logic                 zero_s1, flt_s1;
	logic [SW-1:0]        side_s1;

	always_comb begin
		zero = (in_den <= 0);
		flt  = zero;
		numc = in_num;
		if (in_num > in_den) begin
			numc = in_den;
			flt  = 1'b1;
		end else if (in_num < -in_den) begin
			numc = -in_den;
			flt  = 1'b1;
		end
		msb = '0;
		for (int k = 0; k < NW; k++) begin
			if (in_den[k]) msb = MSB_W'(k);
		end
	end

	// stage b
	logic signed [NW-1:0] nsh, dsh;
	logic signed [NW-1:0] nclp;
	logic signed [NB-1:0] num_s2;
	logic [30:0]          den_s2;
	logic [KW-1:0]        k_s2;

	always_comb begin
		if (msb_s1 > MSB_W'(NORM_SH)) begin
			nsh = num_s1 >>> (msb_s1 - MSB_W'(NORM_SH));
			dsh = den_s1 >>> (msb_s1 - MSB_W'(NORM_SH));
		end else begin
			nsh = num_s1 <<< (MSB_W'(NORM_SH) - msb_s1);
			dsh = den_s1 <<< (MSB_W'(NORM_SH) - msb_s1);
		end
		nclp = nsh;
		if (nsh > dsh) nclp = dsh;
		else if (nsh < -dsh) nclp = -dsh;
	end

	// stage c and d
	logic signed [2*NB-1:0] nsq_full;
	logic [RW-1:0]          dsq_s3, nsq_s3;
	logic [KW-1:0]          k_s3;

	assign nsq_full = num_s2 * num_s2;

	// square root stages; index 0 is stage d
	logic [RW-1:0] qn_s [0:ISQ];
	logic [RW-1:0] qr_s [0:ISQ];
	logic [KW-1:0] qk_s [0:ISQ];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[LAT-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s1  <= numc;
			den_s1  <= in_den;
			msb_s1  <= msb;
			zero_s1 <= zero;
			flt_s1  <= flt;
			side_s1 <= in_side;

			num_s2 <= NB'(nclp);
			den_s2 <= dsh[30:0];
			k_s2   <= {zero_s1, flt_s1, side_s1, NB'(nclp)};

			dsq_s3 <= den_s2 * den_s2;
			nsq_s3 <= nsq_full[RW-1:0];
			k_s3   <= k_s2;

			qn_s[0] <= dsq_s3 - nsq_s3;
			qr_s[0] <= '0;
			qk_s[0] <= k_s3;
			for (int g = 0; g < ISQ; g++) begin
				qk_s[g+1] <= qk_s[g];
				if (qn_s[g] >= qr_s[g] + (RW'(1) << (60 - 2*g))) begin
					qn_s[g+1] <= qn_s[g] - (qr_s[g] + (RW'(1) << (60 - 2*g)));
					qr_s[g+1] <= (qr_s[g] >> 1) + (RW'(1) << (60 - 2*g));
				end else begin
					qn_s[g+1] <= qn_s[g];
					qr_s[g+1] <= qr_s[g] >> 1;
				end
			end
		end
	end

	logic signed [AW-1:0] cx, cy;
	logic signed [AW-1:0] cx_out;
	logic [SW:0]          cside;

	assign cx = AW'($signed(qk_s[ISQ][NB-1:0]));
	assign cy = $signed(AW'(qr_s[ISQ][30:0]));

	tjik_vec_cordic #(
		.W     (AW),
		.STEPS (STEPS),
		.SW    (SW + 1)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_q[LAT-1]),
		.in_clr    (qk_s[ISQ][KW-1]),
		.in_x      (cx),
		.in_y      (cy),
		.in_side   (qk_s[ISQ][KW-2:NB]),
		.out_valid (out_valid),
		.out_angle (out_angle),
		.out_x     (cx_out),
		.out_side  (cside)
	);

	assign out_fault = cside[SW] | (cx_out == '0 && cx_out != '0);
	assign out_side  = cside[SW-1:0];

endmodule

### sv/three_joint_leg_inverse_kinematics_core.sv
// ----------------------------------------------------------------------------
// three_joint_leg_inverse_kinematics_core
// Toe target in, coxa yaw, femur pitch and tibia bend out, fixed point.
//
//   channel  dir  beat contents (lowest bits first)
//   s_*      in   tdata: toe_x, toe_y, toe_z
//   m_*      out  tdata: hip_yaw_angle, femur_pitch_angle, tibia_bend_angle
//                 tuser: reach_fault
//   cfg_*    in   cfg_index, cfg_data (coxa, femur, tibia, leg_corner)
//
// One toe target per cycle while the output skid register is empty. The path
// runs through three CORDIC pipelines in series and the 31-stage square root.
// Reset clears valid bits and loads the default link lengths; no clear pass.
// The whole pipeline holds while the output skid register is occupied.
// ----------------------------------------------------------------------------
module three_joint_leg_inverse_kinematics_core
	import tjik_pkg::*;
#(
	parameter int CORDIC_STEPS        = CORDIC_STEPS_DEF,
	parameter int COORD_BITS          = COORD_BITS_DEF,
	parameter int ANGLE_FRACTION_BITS = ANGLE_FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((3*COORD_BITS+7)/8)*8-1:0]    s_tdata,   // toe_x, toe_y, toe_z
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [47:0]                          m_tdata,   // yaw, pitch, bend
	output logic                                 m_tuser,   // reach_fault
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [7:0]                           cfg_index,
	input  logic [LEN_W-1:0]                     cfg_data
);

	localparam int GUARD = 36 - COORD_BITS;
	localparam int HSH   = 30 - GUARD;
	localparam int DSH   = GUARD - 4;
	localparam int SH    = AQ - ANGLE_FRACTION_BITS;
	localparam logic [42:0] HIP_RST_FULL = 43'(13'd1280) * 43'(INV_SQRT2_Q30);
	localparam logic [CW-1:0] HIP_RST    = CW'(HIP_RST_FULL >> HSH);
	localparam logic [CW:0]   RND        = ((CW+1)'(1) << DSH) >> 1;
	localparam logic signed [ANG_W-1:0] RH = ANG_W'(1) <<< (SH - 1);

	logic                en;
	logic [LEN_W-1:0]    coxa_q, femur_q, tibia_q;
	corner_t             corner_q;
	logic [CW-1:0]       hip_q;
	logic [42:0]         hip_full;

	assign cfg_ready = 1'b1;
	assign hip_full  = 43'({1'b0, coxa_q} + {1'b0, femur_q}) * 43'(INV_SQRT2_Q30);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coxa_q   <= 12'd480;
			femur_q  <= 12'd800;
			tibia_q  <= 12'd1280;
			corner_q <= CORNER_BACK_LEFT;
			hip_q    <= HIP_RST;
		end else begin
			hip_q <= CW'(hip_full >> HSH);
			if (cfg_valid) begin
				case (cfg_reg_t'(cfg_index))
					REG_COXA:   coxa_q   <= cfg_data;
					REG_FEMUR:  femur_q  <= cfg_data;
					REG_TIBIA:  tibia_q  <= cfg_data;
					REG_CORNER: corner_q <= corner_t'(cfg_data[1:0]);
					default: ;
				endcase
			end
		end
	end

	// stage 1: offsets from hip to toe
	logic signed [COORD_BITS-1:0] toe_x, toe_y, toe_z;
	logic signed [CW-1:0] hipw, hx, hy, dx, dy, dz;
	logic signed [CW-1:0] dx_s1, dy_s1, dz_s1;
	logic                 v_s1;

	assign toe_x = s_tdata[COORD_BITS-1:0];
	assign toe_y = s_tdata[2*COORD_BITS-1:COORD_BITS];
	assign toe_z = s_tdata[3*COORD_BITS-1:2*COORD_BITS];
	assign hipw  = $signed(hip_q);

	always_comb begin
		hx = hipw;
		hy = hipw;
		case (corner_q)
			CORNER_FRONT_RIGHT: begin
				hx = -hipw;
				hy = -hipw;
			end
			CORNER_FRONT_LEFT:  hy = -hipw;
			CORNER_BACK_RIGHT:  hx = -hipw;
			default: ;
		endcase
		dx = (CW'(toe_x) <<< GUARD) - hx;
		dy = (CW'(toe_y) <<< GUARD) - hy;
		dz = (CW'(toe_z) - $signed(CW'(tibia_q))) <<< GUARD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= dx;
			dy_s1 <= dy;
			dz_s1 <= dz;
		end
	end

	// yaw and horizontal reach
	logic                    c1_v, m1_v;
	logic signed [ANG_W-1:0] yaw_c1;
	logic signed [CW-1:0]    c1_x, dz_c1;
	logic [CW-1:0]           horiz;
	logic [ANG_W+CW-1:0]     m1_side;

	tjik_vec_cordic #(.W(CW), .STEPS(CORDIC_STEPS), .SW(CW)) u_cordic_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.in_clr    (1'b0),
		.in_x      (dx_s1),
		.in_y      (dy_s1),
		.in_side   (dz_s1),
		.out_valid (c1_v),
		.out_angle (yaw_c1),
		.out_x     (c1_x),
		.out_side  (dz_c1)
	);

	tjik_mag #(.W(CW), .SW(ANG_W + CW)) u_mag_horiz (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (c1_v),
		.in_x      (c1_x),
		.in_side   ({yaw_c1, dz_c1}),
		.out_valid (m1_v),
		.out_mag   (horiz),
		.out_side  (m1_side)
	);

	// stage 2: femur-side horizontal offset
	logic signed [CW-1:0]    fth_s2, dz_s2;
	logic signed [ANG_W-1:0] yaw_s2;
	logic                    v_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= m1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fth_s2 <= $signed(horiz) - $signed(CW'(coxa_q) << GUARD);
			dz_s2  <= m1_side[CW-1:0];
			yaw_s2 <= m1_side[ANG_W+CW-1:CW];
		end
	end

	// elevation and diagonal
	logic                    c2_v, m2_v;
	logic signed [ANG_W-1:0] elev_c2, yaw_c2;
	logic signed [CW-1:0]    c2_x;
	logic [CW-1:0]           diag;
	logic [2*ANG_W-1:0]      m2_side;

	tjik_vec_cordic #(.W(CW), .STEPS(CORDIC_STEPS), .SW(ANG_W)) u_cordic_elev (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_clr    (1'b0),
		.in_x      (fth_s2),
		.in_y      (dz_s2),
		.in_side   (yaw_s2),
		.out_valid (c2_v),
		.out_angle (elev_c2),
		.out_x     (c2_x),
		.out_side  (yaw_c2)
	);

	tjik_mag #(.W(CW), .SW(2 * ANG_W)) u_mag_diag (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (c2_v),
		.in_x      (c2_x),
		.in_side   ({yaw_c2, elev_c2}),
		.out_valid (m2_v),
		.out_mag   (diag),
		.out_side  (m2_side)
	);

	// stages 3 to 5: diagonal rounding, products, cosine ratios
	logic [CW:0]             dsum, dfull;
	logic [DQ_W-1:0]         dq_s3;
	logic [35:0]             dd_s4;
	logic [31:0]             ff_s4, tt_s4, ft_s4;
	logic [33:0]             df_s4;
	logic signed [NW-1:0]    num1_s5, den1_s5, num2_s5, den2_s5;
	logic signed [ANG_W-1:0] yaw_s3, elev_s3, yaw_s4, elev_s4, yaw_s5, elev_s5;
	logic [2:0]              v_s345;
	logic [15:0]             fq, tq;

	assign dsum  = (CW+1)'(diag) + RND;
	assign dfull = dsum >> DSH;
	assign fq    = {femur_q, 4'b0};
	assign tq    = {tibia_q, 4'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s345 <= '0;
		end else if (en) begin
			v_s345 <= {v_s345[1:0], m2_v};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dq_s3   <= (dfull > (CW+1)'(DIAG_MAX)) ? DIAG_MAX : dfull[DQ_W-1:0];
			yaw_s3  <= m2_side[2*ANG_W-1:ANG_W];
			elev_s3 <= m2_side[ANG_W-1:0];

			dd_s4   <= dq_s3 * dq_s3;
			ff_s4   <= fq * fq;
			tt_s4   <= tq * tq;
			df_s4   <= dq_s3 * fq;
			ft_s4   <= fq * tq;
			yaw_s4  <= yaw_s3;
			elev_s4 <= elev_s3;

			num1_s5 <= $signed(NW'(dd_s4)) + $signed(NW'(ff_s4)) - $signed(NW'(tt_s4));
			den1_s5 <= $signed(NW'({df_s4, 1'b0}));
			num2_s5 <= $signed(NW'(ff_s4)) + $signed(NW'(tt_s4)) - $signed(NW'(dd_s4));
			den2_s5 <= $signed(NW'({ft_s4, 1'b0}));
			yaw_s5  <= yaw_s4;
			elev_s5 <= elev_s4;
		end
	end

	// law-of-cosines angles
	logic                    a1_v, a2_v, f1, f2;
	logic signed [ANG_W-1:0] reach, bend, yaw_a, elev_a;

	tjik_acos #(.STEPS(CORDIC_STEPS), .SW(ANG_W)) u_acos_reach (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s345[2]),
		.in_num    (num1_s5),
		.in_den    (den1_s5),
		.in_side   (yaw_s5),
		.out_valid (a1_v),
		.out_angle (reach),
		.out_fault (f1),
		.out_side  (yaw_a)
	);

	tjik_acos #(.STEPS(CORDIC_STEPS), .SW(ANG_W)) u_acos_bend (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s345[2]),
		.in_num    (num2_s5),
		.in_den    (den2_s5),
		.in_side   (elev_s5),
		.out_valid (a2_v),
		.out_angle (bend),
		.out_fault (f2),
		.out_side  (elev_a)
	);

	// rounding and output skid buffer
	logic signed [ANG_W-1:0] yaw_r, pitch_r, bend_r;
	out_beat_t               beat, out_q, skid_q;
	logic                    in_v, out_v_q, skid_v_q;

	assign yaw_r   = (yaw_a + RH) >>> SH;
	assign pitch_r = (reach + elev_a + RH) >>> SH;
	assign bend_r  = (bend + RH) >>> SH;

	always_comb begin
		beat.yaw   = yaw_r[14:0];
		beat.pitch = pitch_r[15:0];
		beat.bend  = bend_r[13:0];
		beat.fault = f1 | f2;
	end

	assign en       = !skid_v_q;
	assign s_tready = en;
	assign in_v     = a1_v && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= in_v;
			end
		end else if (in_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= skid_v_q ? skid_q : beat;
		end else if (in_v) begin
			skid_q <= beat;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {3'b000, out_q.bend, out_q.pitch, out_q.yaw};
	assign m_tuser  = out_q.fault;

	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a beat while the output register is empty");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !m_tready && skid_v_q) |=> (skid_v_q && out_v_q))
		else $error("stalled beat dropped from the output buffer");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_tready && a2_v))
		else $error("skid filled without a stalled output and a finished beat");

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives toe targets through the leg inverse kinematics core under random
// stalls on both streams and compares each output beat with joint angles
// worked out by a fixed point predictor kept in this file.
// ----------------------------------------------------------------------------
module testbench;
	import tjik_pkg::*;

	localparam logic [7:0] UNUSED_INDEX = 8'd9;
	localparam int         SETTLE       = 3 * CORDIC_STEPS_DEF + 64;
	localparam int         STALL_LIMIT  = 4000;

	typedef struct {
		logic [14:0] yaw;
		logic [15:0] pitch;
		logic [13:0] bend;
		logic        fault;
	} joint_angles_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [11:0] cfg_data  = '0;

	joint_angles_t angles_due[$];
	int            errors     = 0;
	int            idle_count = 0;
	bit            no_idle    = 0;
	bit            hold_req   = 0;

	longint        leg_coxa, leg_femur, leg_tibia;
	corner_t       leg_pos;

	three_joint_leg_inverse_kinematics_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Predictor ---------------------------------------------------------------
	function automatic longint vector_angle(input longint xi, input longint yi,
			output longint mag);
		longint x, y, z, t, nx, ny;
		x = xi;
		y = yi;
		z = 0;
		if (x == 0 && y == 0) begin
			mag = 0;
			return 0;
		end
		if (x < 0) begin
			t = x;
			if (y >= 0) begin
				x = y; y = -t; z = longint'(DEG90);
			end else begin
				x = -y; y = t; z = -longint'(DEG90);
			end
		end
		for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += longint'(ATAN_Q20[i]);
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= longint'(ATAN_Q20[i]);
			end
			x = nx;
			y = ny;
		end
		mag = (x * longint'(INVK_Q24)) >>> 24;
		return z;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint cosine_angle(input longint num, input longint den,
			inout bit fault);
		longint unsigned s;
		longint m;
		if (den <= 0) begin
			fault = 1;
			return 0;
		end
		if (num > den) begin num = den; fault = 1; end
		if (num < -den) begin num = -den; fault = 1; end
		while (den >= (64'sd1 <<< 31)) begin
			den = den >>> 1;
			num = num >>> 1;
		end
		while (den < (64'sd1 <<< 30)) begin
			den *= 2;
			num *= 2;
		end
		if (num > den) num = den;
		if (num < -den) num = -den;
		s = int_sqrt(longint'(den * den - num * num));
		return vector_angle(num, longint'(s), m);
	endfunction

	function automatic longint to_degrees64(input longint a);
		return (a + (64'sd1 <<< 13)) >>> 14;
	endfunction

	function automatic joint_angles_t solve_leg(input logic signed [15:0] tx,
			input logic signed [15:0] ty, input logic signed [15:0] tz);
		joint_angles_t r;
		longint hip, hx, hy, dx, dy, dz, horiz, fth, diag, dq, fq, tq;
		longint yaw, elev, reach, bend;
		bit fault;
		fault = 0;
		hip = ((leg_coxa + leg_femur) * longint'(INV_SQRT2_Q30)) >>> 10;
		hx = hip;
		hy = hip;
		case (leg_pos)
			CORNER_FRONT_RIGHT: begin hx = -hip; hy = -hip; end
			CORNER_FRONT_LEFT:  hy = -hip;
			CORNER_BACK_RIGHT:  hx = -hip;
			default: ;
		endcase
		dx = longint'(tx) * (64'sd1 <<< 20) - hx;
		dy = longint'(ty) * (64'sd1 <<< 20) - hy;
		dz = (longint'(tz) - leg_tibia) * (64'sd1 <<< 20);
		yaw = vector_angle(dx, dy, horiz);
		fth = horiz - leg_coxa * (64'sd1 <<< 20);
		elev = vector_angle(fth, dz, diag);
		dq = (diag + (64'sd1 <<< 15)) >>> 16;
		if (dq > longint'(DIAG_MAX)) dq = longint'(DIAG_MAX);
		fq = leg_femur * 16;
		tq = leg_tibia * 16;
		reach = cosine_angle(dq * dq + fq * fq - tq * tq, 2 * dq * fq, fault);
		bend = cosine_angle(fq * fq + tq * tq - dq * dq, 2 * fq * tq, fault);
		r.yaw = 15'(to_degrees64(yaw));
		r.pitch = 16'(to_degrees64(reach + elev));
		r.bend = 14'(to_degrees64(bend));
		r.fault = fault;
		return r;
	endfunction

	// Result side ------------------------------------------------------------
	always @(negedge clk) begin
		int hold_left;
		if (hold_req) begin
			hold_req = 0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (no_idle) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(99) >= 36);
	end

	always @(posedge clk) begin
		joint_angles_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (angles_due.size() == 0) begin
				$error("output beat with no toe target pending");
				errors++;
			end else begin
				e = angles_due.pop_front();
				if (m_tdata[14:0] !== e.yaw) begin
					$error("hip_yaw_angle exp %0h got %0h", e.yaw, m_tdata[14:0]);
					errors++;
				end
				if (m_tdata[30:15] !== e.pitch) begin
					$error("femur_pitch_angle exp %0h got %0h", e.pitch, m_tdata[30:15]);
					errors++;
				end
				if (m_tdata[44:31] !== e.bend) begin
					$error("tibia_bend_angle exp %0h got %0h", e.bend, m_tdata[44:31]);
					errors++;
				end
				if (m_tuser !== e.fault) begin
					$error("reach_fault exp %0b got %0b", e.fault, m_tuser);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_count <= 0;
		else idle_count <= idle_count + 1;
		if (idle_count >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Stimulus helpers -------------------------------------------------------
	task automatic send_toe(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic signed [15:0] z);
		int gap;
		gap = (!no_idle && $urandom_range(99) < 36) ? $urandom_range(1, 3) : 0;
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= {z, y, x};
		do @(posedge clk); while (!s_tready);
		angles_due.push_back(solve_leg(x, y, z));
	endtask

	task automatic drain;
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (angles_due.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [11:0] val);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_COXA:   leg_coxa = val;
			REG_FEMUR:  leg_femur = val;
			REG_TIBIA:  leg_tibia = val;
			REG_CORNER: leg_pos = corner_t'(val[1:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_leg(input int c, input int f, input int t, input corner_t p);
		write_reg(REG_COXA, 12'(c));
		write_reg(REG_FEMUR, 12'(f));
		write_reg(REG_TIBIA, 12'(t));
		write_reg(REG_CORNER, 12'(p));
	endtask

	function automatic logic signed [15:0] near_coord(input int span);
		return 16'($urandom_range(0, 2 * span) - span);
	endfunction

	task automatic send_random(input int n);
		int span;
		span = int'(leg_coxa + leg_femur + leg_tibia) + 200;
		repeat (n) begin
			if ($urandom_range(99) < 70)
				send_toe(near_coord(span), near_coord(span), near_coord(span));
			else send_toe(16'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	// Tests ------------------------------------------------------------------
	task automatic test_directed;
		send_toe(0, 0, 0);
		send_toe(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_toe(-16'sh8000, -16'sh8000, -16'sh8000);
		send_toe(16'sh7FFF, -16'sh8000, 0);
		send_toe(-16'sh8000, 16'sh7FFF, 0);
		send_toe(960, 960, 0);
		send_toe(905, 905, 1280);
		send_toe(905, 905, -1000);
		send_toe(1300, 1300, -200);
		send_toe(1800, 1200, -600);
		send_toe(-1500, 700, 300);
		send_toe(600, -1700, -900);
		send_toe(1000, 1000, 1280);
		send_toe(905, 905, 2000);
		send_toe(0, 0, -32768);
		drain();
	endtask

	task automatic test_corners;
		for (int p = 0; p < 4; p++) begin
			write_reg(REG_CORNER, 12'(p));
			send_toe(0, 0, 0);
			send_random(30);
		end
		write_reg(REG_CORNER, 12'hFFE);
		send_random(20);
	endtask

	task automatic test_length_extremes;
		set_leg(1, 1, 1, CORNER_FRONT_RIGHT);
		send_toe(0, 0, 1);
		send_toe(-1, -1, 0);
		send_random(30);
		set_leg(4095, 4095, 4095, CORNER_BACK_RIGHT);
		send_toe(0, 0, 0);
		send_random(30);
		set_leg(480, 0, 1280, CORNER_BACK_LEFT);
		send_random(15);
		set_leg(480, 800, 0, CORNER_FRONT_LEFT);
		send_random(15);
		write_reg(UNUSED_INDEX, 12'hABC);
		set_leg(480, 800, 1280, CORNER_BACK_LEFT);
		send_random(15);
	endtask

	task automatic test_random_legs;
		repeat (3) begin
			set_leg($urandom_range(1, 4095), $urandom_range(1, 4095), $urandom_range(1, 4095),
				corner_t'($urandom_range(0, 3)));
			send_random(50);
		end
		set_leg($urandom_range(100, 900), $urandom_range(300, 1500),
			$urandom_range(300, 1500), corner_t'($urandom_range(0, 3)));
		send_random(60);
	endtask

	task automatic test_backpressure;
		hold_req = 1;
		send_random(150);
		drain();
	endtask

	task automatic test_full_rate;
		no_idle = 1;
		send_random(100);
		send_toe(10, 10, 10);
		no_idle = 0;
		send_random(30);
		drain();
	endtask

	initial begin
		leg_coxa = 480;
		leg_femur = 800;
		leg_tibia = 1280;
		leg_pos = CORNER_BACK_LEFT;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_corners();
		test_length_extremes();
		test_backpressure();
		test_random_legs();
		test_full_rate();
		drain();
		if (errors == 0) $display("Testbench completed without errors");
		else $display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### three_joint_leg_inverse_kinematics_core.f
sv/tjik_pkg.sv
sv/tjik_vec_cordic.sv
sv/tjik_mag.sv
sv/tjik_acos.sv
sv/three_joint_leg_inverse_kinematics_core.sv
sim/testbench.sv
